>>> hw/rtl/epq_pkg.sv
// Shared types, constants and command structs for the event priority queue.
package epq_pkg;

    localparam int Capacity = 64;
    localparam int AddrW    = $clog2(Capacity);
    localparam int CountW   = $clog2(Capacity + 1);
    localparam int OccW     = 7;
    localparam int EntryW   = 32 + 32 + 17;

    localparam logic       OP_PUSH      = 1'b0;
    localparam logic       OP_POP       = 1'b1;
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic        op;
        logic [31:0] event_time;
        logic [15:0] customer_id;
        logic        event_kind;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_time;
        logic [15:0] out_customer;
        logic        out_kind;
        logic [6:0]  occupancy;
    } out_item_t;

    typedef struct packed {
        logic [31:0] etime;
        logic [31:0] tag;
        logic [16:0] payload;
    } entry_t;

    // x before y in heap order
    function automatic logic earlier(entry_t x, entry_t y);
        logic r;
        if (x.etime != y.etime) begin
            r = x.etime < y.etime;
        end else begin
            r = x.tag < y.tag;
        end
        return r;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic load_req;     // latch request, start an operation
        logic push_init;    // write new entry at the tail, pos = tail
        logic pop_init;     // read top (root) entry
        logic pop_move;     // latch top, read last entry, pos = 0
        logic rd_parent;    // read parent of pos
        logic up_step;      // compare/swap with parent
        logic rd_left;      // read left child
        logic rd_right;     // read right child
        logic dn_step;      // compare/swap with best child
        logic finish;       // write current entry at pos
    } epq_cmd_t;

    typedef struct packed {
        logic is_pop;
        logic empty;
        logic full;
        logic at_root;
        logic has_left;
        logic has_right;
        logic swap_up;
        logic swap_dn;
        logic one_left;     // pop leaves heap empty
    } epq_stat_t;

endpackage

>>> hw/rtl/event_priority_queue.sv
// Top level of the event priority queue: sequencer plus heap datapath.
//
//  channel | ports                       | carries
//  --------+-----------------------------+--------------------------------
//  input   | s_valid s_ready s_data      | push or pop request
//  result  | m_valid m_ready m_data      | status, popped event, occupancy
//
// One request at a time. A push climbs the heap one level per compare until a
// compare stops it or it reaches the root; a pop descends one level per compare
// until a compare stops it or no child is left, and skips the descent when it
// empties the queue. Each compare waits on a read through the single RAM port.
// Reset clears the count and tag counter; the heap RAM needs no clearing.
// A finished result waits in the output register until m_ready; the next
// request may be accepted meanwhile and holds in its last state behind it.
module event_priority_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  epq_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output epq_pkg::out_item_t m_data
);
    epq_pkg::epq_cmd_t  cmd;
    epq_pkg::epq_stat_t stat;
    epq_pkg::out_item_t result;

    epq_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .stat   (stat),
        .result (result),
        .cmd    (cmd),
        .m_data (m_data)
    );

    epq_datapath u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (cmd),
        .req    (s_data),
        .stat   (stat),
        .result (result)
    );
endmodule

>>> hw/rtl/epq_ram.sv
// Generic single-port RAM with registered read.
module epq_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> hw/rtl/epq_datapath.sv
// Heap storage, position registers and compare logic.
module epq_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  epq_pkg::epq_cmd_t   cmd,
    input  epq_pkg::in_item_t   req,
    output epq_pkg::epq_stat_t  stat,
    output epq_pkg::out_item_t  result
);
    localparam int AW = epq_pkg::AddrW;
    localparam int CW = epq_pkg::CountW;

    epq_pkg::in_item_t req_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [31:0]       tag_reg, tag_next;
    logic [AW-1:0]     pos_reg, pos_next, child_reg, child_next;
    epq_pkg::entry_t   cur_reg, cur_next, best_reg, best_next;
    epq_pkg::entry_t   top_reg, top_next;
    logic              have_left_reg, have_left_next;

    logic            we;
    logic [AW-1:0]   addr;
    epq_pkg::entry_t wdata, rdata;

    epq_ram #(.Width(epq_pkg::EntryW), .Depth(epq_pkg::Capacity)) u_ram (
        .aclk (aclk),
        .we   (we),
        .addr (addr),
        .wdata(wdata),
        .rdata(rdata)
    );

    logic [CW:0] left_w, right_w;
    logic [AW-1:0] parent_w;
    logic          has_right_w;
    assign left_w      = {1'b0, pos_reg, 1'b1};
    assign right_w     = left_w + 1'b1;
    assign parent_w    = AW'((pos_reg - 1'b1) >> 1);
    assign has_right_w = right_w < (CW+1)'(count_reg);

    // best of current, left and right; rdata holds the right child
    epq_pkg::entry_t dn_best_w;
    logic [AW-1:0]   dn_child_w;
    always_comb begin
        dn_best_w  = best_reg;
        dn_child_w = child_reg;
        if (has_right_w && epq_pkg::earlier(rdata, best_reg)) begin
            dn_best_w  = rdata;
            dn_child_w = AW'(right_w);
        end
    end

    always_comb begin
        stat.is_pop    = req_reg.op == epq_pkg::OP_POP;
        stat.empty     = count_reg == '0;
        stat.full      = count_reg >= CW'(epq_pkg::Capacity);
        stat.at_root   = pos_reg == '0;
        stat.has_left  = (CW+1)'(left_w) < (CW+1)'(count_reg);
        stat.has_right = has_right_w;
        stat.swap_up   = epq_pkg::earlier(cur_reg, rdata);
        stat.swap_dn   = dn_child_w != pos_reg;
        stat.one_left  = count_reg == CW'(1);
    end

    always_comb begin
        count_next     = count_reg;
        tag_next       = tag_reg;
        pos_next       = pos_reg;
        child_next     = child_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        top_next       = top_reg;
        have_left_next = have_left_reg;
        we    = 1'b0;
        addr  = pos_reg;
        wdata = cur_reg;
        if (cmd.push_init) begin
            cur_next = '{etime: req_reg.event_time, tag: tag_reg,
                         payload: {req_reg.event_kind, req_reg.customer_id}};
            we    = 1'b1;
            addr  = AW'(count_reg);
            wdata = cur_next;
            pos_next   = AW'(count_reg);
            count_next = count_reg + 1'b1;
            tag_next   = tag_reg + 1'b1;
        end
        if (cmd.pop_init) begin
            // read root; last entry read next cycle
            addr = '0;
        end
        if (cmd.pop_move) begin
            // rdata holds root; fetch last entry
            top_next   = rdata;
            count_next = count_reg - 1'b1;
            addr       = AW'(count_reg - 1'b1);
            pos_next   = '0;
        end
        if (cmd.rd_parent) begin
            addr = parent_w;
        end
        if (cmd.up_step) begin
            // rdata holds parent: swap if current is earlier
            if (stat.swap_up) begin
                we    = 1'b1;
                addr  = pos_reg;
                wdata = rdata;
                pos_next = parent_w;
            end
        end
        if (cmd.rd_left) begin
            if (pos_reg == '0 && !have_left_reg) begin
                // first step after pop_move: rdata is the last entry
                cur_next = rdata;
            end
            addr = AW'(left_w);
            have_left_next = 1'b0;
        end
        if (cmd.rd_right) begin
            // rdata is left child
            best_next  = cur_reg;
            child_next = pos_reg;
            if (epq_pkg::earlier(rdata, cur_reg)) begin
                best_next  = rdata;
                child_next = AW'(left_w);
            end
            addr = AW'(right_w);
        end
        if (cmd.dn_step) begin
            best_next  = dn_best_w;
            child_next = dn_child_w;
            if (dn_child_w != pos_reg) begin
                we    = 1'b1;
                addr  = pos_reg;
                wdata = dn_best_w;
                pos_next = dn_child_w;
                have_left_next = 1'b1;
            end
        end
        if (cmd.finish) begin
            we    = 1'b1;
            addr  = pos_reg;
            wdata = cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= req;
        end
        pos_reg   <= pos_next;
        child_reg <= child_next;
        cur_reg   <= cur_next;
        best_reg  <= best_next;
        top_reg   <= top_next;
        if (!aresetn) begin
            count_reg     <= '0;
            tag_reg       <= '0;
            have_left_reg <= 1'b1;
        end else begin
            count_reg     <= count_next;
            tag_reg       <= tag_next;
            have_left_reg <= cmd.pop_move ? 1'b0 : have_left_next;
        end
    end

    always_comb begin
        result.status       = epq_pkg::STATUS_OK;
        result.out_time     = '0;
        result.out_customer = '0;
        result.out_kind     = 1'b0;
        result.occupancy    = 7'(count_reg);
        if (req_reg.op == epq_pkg::OP_POP) begin
            result.out_time     = top_reg.etime;
            result.out_customer = top_reg.payload[15:0];
            result.out_kind     = top_reg.payload[16];
        end
    end
endmodule

>>> hw/rtl/epq_ctrl.sv
// Sequencer for push sift-up and pop sift-down.
module epq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  epq_pkg::epq_stat_t  stat,
    input  epq_pkg::out_item_t  result,
    output epq_pkg::epq_cmd_t   cmd,
    output epq_pkg::out_item_t  m_data
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_UP_RD  = 4'd2;
    localparam logic [3:0] S_UP_CMP = 4'd3;
    localparam logic [3:0] S_POP_RD = 4'd4;
    localparam logic [3:0] S_POP_MV = 4'd5;
    localparam logic [3:0] S_DN_L   = 4'd6;
    localparam logic [3:0] S_DN_R   = 4'd7;
    localparam logic [3:0] S_DN_CMP = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    epq_pkg::out_item_t m_data_reg, m_data_next;
    logic [1:0] st_reg, st_next;

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        st_next      = st_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                st_next = epq_pkg::STATUS_OK;
                if (stat.is_pop) begin
                    if (stat.empty) begin
                        st_next    = epq_pkg::STATUS_EMPTY;
                        state_next = S_DONE;
                    end else begin
                        cmd.pop_init = 1'b1;
                        state_next   = S_POP_RD;
                    end
                end else if (stat.full) begin
                    st_next    = epq_pkg::STATUS_FULL;
                    state_next = S_DONE;
                end else begin
                    cmd.push_init = 1'b1;
                    state_next    = S_UP_RD;
                end
            end
            S_UP_RD: begin
                if (stat.at_root) begin
                    state_next = S_FIN;
                end else begin
                    cmd.rd_parent = 1'b1;
                    state_next    = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                cmd.up_step = 1'b1;
                state_next  = stat.swap_up ? S_UP_RD : S_FIN;
            end
            S_POP_RD: begin
                cmd.pop_move = 1'b1;
                state_next   = stat.one_left ? S_DONE : S_DN_L;
            end
            S_DN_L: begin
                cmd.rd_left = 1'b1;
                state_next  = stat.has_left ? S_DN_R : S_FIN;
            end
            S_DN_R: begin
                cmd.rd_right = 1'b1;
                state_next   = S_DN_CMP;
            end
            S_DN_CMP: begin
                cmd.dn_step = 1'b1;
                state_next  = stat.swap_dn ? S_DN_L : S_FIN;
            end
            S_FIN: begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg) begin
                    cmd.finish   = 1'b0;
                    m_data_next  = result;
                    m_data_next.status = st_reg;
                    if (st_reg != epq_pkg::STATUS_OK) begin
                        m_data_next.out_time     = '0;
                        m_data_next.out_customer = '0;
                        m_data_next.out_kind     = 1'b0;
                    end
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        st_reg     <= st_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end
endmodule

>>> tb/epq_checker.sv
// Checker for the event priority queue: heap predictor and result comparison.
`timescale 1ns / 100ps
module epq_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  epq_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  epq_pkg::out_item_t m_data,
    output int                 fail_count,
    output int                 pending
);

    epq_pkg::entry_t    heap_q[$];
    logic [31:0]        seq_tag;
    epq_pkg::out_item_t expected_q[$];

    // heap kept as a sorted list; order is time then tag
    function automatic epq_pkg::out_item_t apply_request(epq_pkg::in_item_t req);
        epq_pkg::out_item_t res;
        epq_pkg::entry_t    e;
        int                 pos;
        res = '0;
        if (req.op == epq_pkg::OP_PUSH) begin
            if (heap_q.size() >= epq_pkg::Capacity) begin
                res.status = epq_pkg::STATUS_FULL;
            end else begin
                e.etime   = req.event_time;
                e.tag     = seq_tag;
                e.payload = {req.event_kind, req.customer_id};
                seq_tag   = seq_tag + 32'd1;
                pos = heap_q.size();
                for (int i = 0; i < heap_q.size(); i++) begin
                    if (e.etime < heap_q[i].etime ||
                        (e.etime == heap_q[i].etime && e.tag < heap_q[i].tag)) begin
                        pos = i;
                        break;
                    end
                end
                heap_q.insert(pos, e);
                res.status = epq_pkg::STATUS_OK;
            end
        end else begin
            if (heap_q.size() == 0) begin
                res.status = epq_pkg::STATUS_EMPTY;
            end else begin
                e = heap_q.pop_front();
                res.status       = epq_pkg::STATUS_OK;
                res.out_time     = e.etime;
                res.out_customer = e.payload[15:0];
                res.out_kind     = e.payload[16];
            end
        end
        res.occupancy = 7'(heap_q.size());
        return res;
    endfunction

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        epq_pkg::out_item_t want;
        if (!aresetn) begin
            heap_q.delete();
            expected_q.delete();
            seq_tag     = 32'd0;
            fail_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result %p", m_data);
                end else begin
                    want = expected_q.pop_front();
                    if (want !== m_data) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected %p, got %p", want, m_data);
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_q.push_back(apply_request(s_data));
            end
        end
    end

    initial fail_count = 0;
    initial seq_tag = 32'd0;

endmodule

>>> tb/tb_top.sv
// Top of the event priority queue testbench: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps
module tb_top;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    epq_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    epq_pkg::out_item_t m_data;
    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;
    logic               calm = 1'b0;
    int                 hold_off = 0;
    logic               long_go = 1'b0;
    logic               long_done = 1'b0;

    always #5 aclk = ~aclk;

    event_priority_queue dut (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    epq_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off
    always @(posedge aclk) begin
        int burst;
        if (long_go && !long_done) begin
            m_ready   <= 1'b0;
            hold_off  <= 300;
            long_done <= 1'b1;
        end else if (hold_off > 0) begin
            m_ready  <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 9);
            m_ready  <= 1'b0;
            hold_off <= burst - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_request(input epq_pkg::in_item_t req);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic epq_pkg::in_item_t make_push(logic [31:0] t, logic [15:0] c,
                                                    logic k);
        epq_pkg::in_item_t r;
        r.op = epq_pkg::OP_PUSH; r.event_time = t; r.customer_id = c; r.event_kind = k;
        return r;
    endfunction

    function automatic epq_pkg::in_item_t make_pop();
        epq_pkg::in_item_t r;
        r = '0;
        r.op = epq_pkg::OP_POP;
        r.event_time = $urandom; r.customer_id = 16'($urandom);
        r.event_kind = 1'($urandom);
        return r;
    endfunction

    function automatic epq_pkg::in_item_t random_push(int spread);
        return make_push(spread == 0 ? $urandom : 32'($urandom_range(0, spread)),
                         16'($urandom), 1'($urandom));
    endfunction

    initial begin
        int waited;
        int mode;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty pop, extremes, ties, then drain past empty
        send_request(make_pop());
        send_request(make_push(32'hFFFF_FFFF, 16'hFFFF, 1'b1));
        send_request(make_push(32'h0, 16'h0, 1'b0));
        send_request(make_push(32'h8000_0000, 16'h1234, 1'b1));
        send_request(make_push(32'h8000_0000, 16'h5678, 1'b0));
        send_request(make_push(32'h8000_0000, 16'h9ABC, 1'b1));
        repeat (6) send_request(make_pop());

        // long hold-off while the queue fills beyond capacity
        long_go <= 1'b1;
        for (int i = 0; i < 70; i++) send_request(random_push(i % 2 ? 15 : 0));
        repeat (66) send_request(make_pop());

        // random phase: mixed push/pop, walking the fill level up and down
        for (int i = 0; i < 1800; i++) begin
            if (i == 1500) calm <= 1'b1;
            mode = (i / 200) % 3;
            if ($urandom_range(0, 99) < (mode == 0 ? 50 : (mode == 1 ? 75 : 30)))
                send_request(random_push(($urandom_range(0, 1) == 1) ? 7 : 0));
            else
                send_request(make_pop());
        end
        s_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
